// ----- hw/rtl/svae_pkg.sv -----
// svae_pkg: widths, payload types and reset constants for the sun vector block
// shared by the front, queue, back and top level; no dependencies
package svae_pkg;

  localparam int unsigned RW        = 16;                 // photodiode reading width
  localparam int unsigned FRAC      = 14;                 // q1.14 output fraction bits
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned THR_W     = 17;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(2654);
  localparam int unsigned MAG_W     = RW - 1;             // clamped axis magnitude
  localparam int unsigned SQ_W      = 2 * MAG_W;
  localparam int unsigned M_W       = SQ_W + 2;           // sum of three squares
  localparam int unsigned Q_W       = FRAC + 1;           // quotient bits, 2^14 max
  localparam int unsigned PW        = M_W + 2 * Q_W;      // holds q^2 * m
  localparam int unsigned ABS_W     = RW;
  localparam int unsigned SUM_W     = RW + 2;
  localparam int unsigned CMP_W     = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic signed [RW-1:0] reading_px;
    logic signed [RW-1:0] reading_nx;
    logic signed [RW-1:0] reading_py;
    logic signed [RW-1:0] reading_ny;
    logic signed [RW-1:0] reading_pz;
    logic signed [RW-1:0] reading_nz;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sun_x;
    logic signed [OUT_W-1:0] sun_y;
    logic signed [OUT_W-1:0] sun_z;
    logic                    no_sun;
    logic                    eclipsed;
  } out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  eclipsed;
  } item_t;

endpackage

// ----- hw/rtl/sun_vector_and_eclipse_top.sv -----
// Coarse sun sensor: six photodiode readings in, unit sun vector and flags out.
// Input channel: in_valid_i / in_stall_o with in_data_i (six signed readings,
// lsb 2^-14 V). Output channel: out_valid_o / out_stall_i with out_data_o
// (sun_x/y/z in q1.14, no_sun, eclipsed). A transfer happens on a rising edge
// where valid is high and stall is low. One result per reading set, in order.
// Throughput: one reading set per cycle while the output is not stalled. From input
// transfer to output valid an item passes the front register, queue, squares,
// magnitude sum, one stage per quotient bit for 15 bits, and the output register.
// Threshold register: cfg_we_i writes cfg_wdata_i (17 bits); write it only when
// the pipeline is empty. eclipsed is set when the summed absolute axis readings
// are below it.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the threshold
// with 2654. When the receiver stalls, the output holds and the pipeline fills
// up stage by stage; in_stall_o rises only once every stage and the queue hold
// an item, and a stalled output transfer never loses or repeats a result.
// Depends on svae_pkg, svae_front, svae_fifo, svae_back.
module sun_vector_and_eclipse_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  svae_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output svae_pkg::out_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic [svae_pkg::THR_W-1:0] cfg_wdata_i
);

  logic [svae_pkg::THR_W-1:0] threshold_q;
  logic            fr_valid, fr_ready, bk_valid, bk_ready;
  svae_pkg::item_t fr_item, bk_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) threshold_q <= svae_pkg::THR_RESET;
    else if (cfg_we_i) threshold_q <= cfg_wdata_i;
  end

  svae_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .threshold_i  (threshold_q),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  svae_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_item),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_item)
  );

  svae_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef ASSERT_OFF
  a_no_sun_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_sun |->
      out_data_o.sun_x == '0 && out_data_o.sun_y == '0 && out_data_o.sun_z == '0)
    else $error("no_sun result carries a nonzero vector");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.sun_x <= 16'sd16384 && out_data_o.sun_x >= -16'sd16384 &&
      out_data_o.sun_y <= 16'sd16384 && out_data_o.sun_y >= -16'sd16384 &&
      out_data_o.sun_z <= 16'sd16384 && out_data_o.sun_z >= -16'sd16384)
    else $error("sun vector component outside unit range");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_valid && !fr_ready |-> bk_valid)
    else $error("queue refuses a transfer while empty");
`endif

endmodule

// ----- hw/rtl/svae_front.sv -----
// svae_front: takes a reading set, picks the clamped axes and flags eclipse
// depends on svae_pkg; one register stage feeding the queue
module svae_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  svae_pkg::in_t               in_data_i,
  input  logic [svae_pkg::THR_W-1:0]  threshold_i,
  output logic                        item_valid_o,
  input  logic                        item_ready_i,
  output svae_pkg::item_t             item_o
);

  localparam int unsigned RW = svae_pkg::RW;

  logic            valid_q;
  svae_pkg::item_t item_q, item_d;
  logic            load;

  function automatic logic [svae_pkg::ABS_W-1:0] abs_pick(
    input logic signed [RW-1:0] p, input logic signed [RW-1:0] n);
    logic signed [RW:0] u;
    u = (p > n) ? {p[RW-1], p} : -{n[RW-1], n};
    abs_pick = u[RW] ? svae_pkg::ABS_W'(-u) : svae_pkg::ABS_W'(u);
  endfunction

  logic signed [5:0][RW-1:0] rd;
  logic [svae_pkg::SUM_W-1:0] total;

  always_comb begin
    logic [svae_pkg::MAG_W-1:0] cp, cn;
    rd = {in_data_i.reading_nz, in_data_i.reading_pz, in_data_i.reading_ny,
          in_data_i.reading_py, in_data_i.reading_nx, in_data_i.reading_px};
    item_d = '0;
    total  = '0;
    for (int i = 0; i < 3; i++) begin
      // negative readings count as zero for the vector
      cp = rd[2*i][RW-1]   ? '0 : rd[2*i][RW-2:0];
      cn = rd[2*i+1][RW-1] ? '0 : rd[2*i+1][RW-2:0];
      if (cp > cn) begin
        item_d.mag[i] = cp;
        item_d.neg[i] = 1'b0;
      end else begin
        item_d.mag[i] = cn;
        item_d.neg[i] = 1'b1;
      end
      total = total + svae_pkg::SUM_W'(abs_pick(rd[2*i], rd[2*i+1]));
    end
    item_d.eclipsed = svae_pkg::CMP_W'(total) < svae_pkg::CMP_W'(threshold_i);
  end

  assign load       = !valid_q || item_ready_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- hw/rtl/svae_fifo.sv -----
// svae_fifo: short queue of classified items between front and back
// depends on svae_pkg for the item type and depth
module svae_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  svae_pkg::item_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output svae_pkg::item_t rd_data_o
);

  localparam int unsigned D  = svae_pkg::FIFO_DEPTH;
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CW = $clog2(D + 1);

  svae_pkg::item_t mem_q [D];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign wr_ready_o = cnt_q != CW'(D);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (p == AW'(D - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= inc(wptr_q);
      if (pop)  rptr_q <= inc(rptr_q);
      if (push && !pop) cnt_q <= cnt_q + CW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hw/rtl/svae_back.sv -----
// svae_back: squares, magnitude sum and bit-per-stage normalization pipeline
// depends on svae_pkg; last stage is the output register
module svae_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  svae_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output svae_pkg::out_t  out_data_o
);

  localparam int unsigned PW = svae_pkg::PW;
  localparam int unsigned NS = svae_pkg::Q_W + 1;   // sum stage plus one per quotient bit

  typedef struct packed {
    logic [2:0][svae_pkg::SQ_W-1:0] sq;
    logic [2:0]                     neg;
    logic                           eclipsed;
  } sq_t;

  // running state: p = q^2 * m, qm = q * m, tested against r = c^2 << 28
  typedef struct packed {
    logic [svae_pkg::M_W-1:0]      m;
    logic [2:0][PW-1:0]            r;
    logic [2:0][PW-1:0]            p;
    logic [2:0][PW-1:0]            qm;
    logic [2:0][svae_pkg::Q_W-1:0] q;
    logic [2:0]                    neg;
    logic                          no_sun;
    logic                          eclipsed;
  } nrm_t;

  sq_t            sq_q;
  logic           sq_vld_q;
  nrm_t           nrm_q   [NS];
  logic [NS-1:0]  nrm_vld_q;
  logic [NS-1:0]  nrm_rdy;
  logic           sq_rdy, out_rdy, out_vld_q;
  svae_pkg::out_t out_q;

  assign out_rdy = !out_vld_q || !out_stall_i;
  assign nrm_rdy[NS-1] = !nrm_vld_q[NS-1] || out_rdy;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign nrm_rdy[k] = !nrm_vld_q[k] || nrm_rdy[k+1];
  end
  assign sq_rdy       = !sq_vld_q || nrm_rdy[0];
  assign item_ready_o = sq_rdy;

  // squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_vld_q <= 1'b0;
    else if (sq_rdy) sq_vld_q <= item_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (sq_rdy && item_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q.sq[i] <= svae_pkg::SQ_W'(item_i.mag[i] * item_i.mag[i]);
      end
      sq_q.neg      <= item_i.neg;
      sq_q.eclipsed <= item_i.eclipsed;
    end
  end

  // magnitude sum
  nrm_t sum_d;
  always_comb begin
    sum_d = '0;
    sum_d.m = svae_pkg::M_W'(sq_q.sq[0]) + svae_pkg::M_W'(sq_q.sq[1])
            + svae_pkg::M_W'(sq_q.sq[2]);
    for (int i = 0; i < 3; i++) begin
      sum_d.r[i] = PW'(sq_q.sq[i]) << (2 * svae_pkg::FRAC);
    end
    sum_d.neg      = sq_q.neg;
    sum_d.no_sun   = sum_d.m == '0;
    sum_d.eclipsed = sq_q.eclipsed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nrm_vld_q[0] <= 1'b0;
    else if (nrm_rdy[0]) nrm_vld_q[0] <= sq_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (nrm_rdy[0] && sq_vld_q) nrm_q[0] <= sum_d;
  end

  // one quotient bit per stage, msb first
  for (genvar k = 1; k < NS; k++) begin : g_step
    localparam int unsigned B = svae_pkg::Q_W - k;
    nrm_t step_d;
    always_comb begin
      logic [PW-1:0] cand;
      step_d = nrm_q[k-1];
      for (int i = 0; i < 3; i++) begin
        cand = nrm_q[k-1].p[i] + (nrm_q[k-1].qm[i] << (B + 1))
             + (PW'(nrm_q[k-1].m) << (2 * B));
        if (cand <= nrm_q[k-1].r[i]) begin
          step_d.p[i]    = cand;
          step_d.qm[i]   = nrm_q[k-1].qm[i] + (PW'(nrm_q[k-1].m) << B);
          step_d.q[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) nrm_vld_q[k] <= 1'b0;
      else if (nrm_rdy[k]) nrm_vld_q[k] <= nrm_vld_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (nrm_rdy[k] && nrm_vld_q[k-1]) nrm_q[k] <= step_d;
    end
  end

  // sign and no-sun forcing into the output register
  svae_pkg::out_t out_d;
  always_comb begin
    logic [2:0][svae_pkg::OUT_W-1:0] comp;
    for (int i = 0; i < 3; i++) begin
      comp[i] = svae_pkg::OUT_W'(nrm_q[NS-1].q[i]);
      if (nrm_q[NS-1].neg[i]) comp[i] = -comp[i];
      if (nrm_q[NS-1].no_sun) comp[i] = '0;
    end
    out_d.sun_x    = comp[0];
    out_d.sun_y    = comp[1];
    out_d.sun_z    = comp[2];
    out_d.no_sun   = nrm_q[NS-1].no_sun;
    out_d.eclipsed = nrm_q[NS-1].eclipsed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (out_rdy) out_vld_q <= nrm_vld_q[NS-1];
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && nrm_vld_q[NS-1]) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
